// File: rtl/dbpc_pkg.sv
// Package with the state encoding and fixed constants of the DC-blocked peak compander.
package dbpc_pkg;

    localparam int SAMPLE_W = 24;
    localparam int RESULT_W = 22;
    localparam int DIV_STEPS = 24;
    localparam int DIV_CNT_W = 5;

    localparam logic [23:0] PEAK_NUMERATOR = 24'd14453571;
    localparam logic signed [31:0] THRESHOLD = 32'sd4129536;
    localparam logic signed [31:0] UNITY_GAIN_Q25 = 32'sd58720256;
    localparam logic signed [31:0] RESET_GAIN_Q25 = 32'sd50331648;
    localparam logic signed [31:0] SAT24_HI = 32'sd8388607;
    localparam logic signed [31:0] SAT24_LO = -32'sd8388608;
    localparam logic signed [34:0] OUT_HI = 35'sd2097151;
    localparam logic signed [34:0] OUT_LO = -35'sd2097152;

    localparam int DC_FAST_SHIFT = 5;
    localparam int DC_SLOW_SHIFT = 4;
    localparam int HP_SHIFT = 6;
    localparam int PEAK_RELEASE_SHIFT = 9;
    localparam int GAIN_ATTACK_SHIFT = 3;
    localparam int GAIN_RELEASE_SHIFT = 12;

    typedef enum logic [4:0] {
        S_IDLE,
        S_F1,
        S_F2,
        S_S1,
        S_S2,
        S_H1,
        S_H2,
        S_H3,
        S_H4,
        S_H5,
        S_P1,
        S_P2,
        S_P3,
        S_DCHK,
        S_DIV,
        S_DQ,
        S_G1,
        S_G2,
        S_MUL,
        S_OUT
    } t_state;

endpackage

// File: rtl/dbpc_if.sv
// Valid/ready channel interfaces for the frame input and the sample output.
interface dbpc_frame_if import dbpc_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       block_end;

    modport source (output valid, output left_sample, output right_sample,
                    output block_end, input ready);
    modport sink   (input valid, input left_sample, input right_sample,
                    input block_end, output ready);
endinterface

interface dbpc_sample_if import dbpc_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [RESULT_W-1:0] companded_sample;
    logic                       block_end_out;

    modport source (output valid, output companded_sample, output block_end_out,
                    input ready);
    modport sink   (input valid, input companded_sample, input block_end_out,
                    output ready);
endinterface

// File: rtl/dc_blocked_peak_compander.sv
// Top level of the DC-blocked peak compander: filter chain, envelope, gain and output.
//
// Each request on i_frame carries one stereo frame; the block sums it to mono, removes DC with
// a fast and a slow tracker and a one-pole high-pass, follows the rectified peak, derives a
// gain from it and answers with one saturated 22-bit sample on o_sample, with block_end
// copied alongside. The filter, envelope and gain updates all run through one shared 32-bit
// adder/subtractor that a small sequencer steps through, one operation per cycle; only the
// final gain multiply uses a separate 21 by 22 bit multiplier. The same adder performs a
// restoring division, one quotient bit per cycle, whenever the envelope is above the limiting
// threshold. When the envelope decays instead of taking a new peak, a decay step is added, and
// above threshold the 24-step division and a quotient step run before the gain update. The
// output step also waits as long as an earlier sample still sits unread in the output
// register, and i_frame.ready is high only between frames. The finished sample sits in an
// output register, so the next frame can be taken while that sample waits for
// o_sample.ready.
module dc_blocked_peak_compander import dbpc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dbpc_frame_if.sink    i_frame,
    dbpc_sample_if.source o_sample
);

    t_state r_state, n_state;

    // Filter and gain state, as 32-bit wrapping two's complement values.
    logic signed [31:0] r_dc_fast, n_dc_fast;
    logic signed [31:0] r_dc_slow, n_dc_slow;
    logic signed [31:0] r_hpt, n_hpt;
    logic signed [31:0] r_env, n_env;
    logic signed [31:0] r_gain, n_gain;

    // Working registers: r_mono holds the mono value, then the high-pass input, then the
    // filtered value; r_acc holds intermediate differences, the rectified value and the target gain.
    logic signed [31:0] r_mono, n_mono;
    logic signed [31:0] r_acc, n_acc;
    logic               r_end, n_end;

    // Restoring divider state.
    logic [15:0]          r_rem, n_rem;
    logic [23:0]          r_quo, n_quo;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;

    logic signed [42:0] r_prod, n_prod;

    // Output register.
    logic                       r_out_valid, n_out_valid;
    logic signed [RESULT_W-1:0] r_out_sample, n_out_sample;
    logic                       r_out_end, n_out_end;

    // Shared adder/subtractor.
    logic [31:0] u_a, u_b, u_sum;
    logic        u_sub;

    logic signed [31:0] fast_sat;
    logic [16:0]        trial;
    logic signed [20:0] filt_hi;
    logic signed [21:0] gain_hi;
    logic signed [34:0] prod_sh;
    logic               accept;

    assign u_sum = u_sub ? (u_a - u_b) : (u_a + u_b);

    assign accept = i_frame.valid && i_frame.ready;
    assign i_frame.ready = (r_state == S_IDLE);

    assign o_sample.valid = r_out_valid;
    assign o_sample.companded_sample = r_out_sample;
    assign o_sample.block_end_out = r_out_end;

    assign fast_sat = (r_dc_fast > SAT24_HI) ? SAT24_HI :
                      ((r_dc_fast < SAT24_LO) ? SAT24_LO : r_dc_fast);
    assign trial = {r_rem, r_quo[23]};
    assign filt_hi = r_mono[31:11];
    assign gain_hi = r_gain[31:10];
    assign prod_sh = r_prod[42:8];

    always_comb begin
        n_state = r_state;
        n_dc_fast = r_dc_fast;
        n_dc_slow = r_dc_slow;
        n_hpt = r_hpt;
        n_env = r_env;
        n_gain = r_gain;
        n_mono = r_mono;
        n_acc = r_acc;
        n_end = r_end;
        n_rem = r_rem;
        n_quo = r_quo;
        n_cnt = r_cnt;
        n_prod = r_prod;
        n_out_valid = r_out_valid;
        n_out_sample = r_out_sample;
        n_out_end = r_out_end;
        u_a = 32'd0;
        u_b = 32'd0;
        u_sub = 1'b0;

        // The waiting sample leaves when the sink takes it.
        if (r_out_valid && o_sample.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    // Sum of two 24-bit samples times 16 fits easily in 32 bits.
                    n_mono = 32'(($signed({{8{i_frame.left_sample[SAMPLE_W-1]}},
                                            i_frame.left_sample})
                                + $signed({{8{i_frame.right_sample[SAMPLE_W-1]}},
                                            i_frame.right_sample})) <<< 4);
                    n_end = i_frame.block_end;
                    n_state = S_F1;
                end
            end
            S_F1: begin
                u_a = r_mono;
                u_b = r_dc_fast;
                u_sub = 1'b1;
                n_acc = $signed(u_sum);
                n_state = S_F2;
            end
            S_F2: begin
                u_a = r_dc_fast;
                u_b = r_acc >>> DC_FAST_SHIFT;
                n_dc_fast = $signed(u_sum);
                n_state = S_S1;
            end
            S_S1: begin
                u_a = fast_sat;
                u_b = r_dc_slow;
                u_sub = 1'b1;
                n_acc = $signed(u_sum);
                n_state = S_S2;
            end
            S_S2: begin
                u_a = r_dc_slow;
                u_b = r_acc >>> DC_SLOW_SHIFT;
                n_dc_slow = $signed(u_sum);
                n_state = S_H1;
            end
            S_H1: begin
                u_a = r_mono;
                u_b = r_dc_fast;
                u_sub = 1'b1;
                n_acc = $signed(u_sum);
                n_state = S_H2;
            end
            S_H2: begin
                // High-pass input replaces the mono value, which is no longer needed.
                u_a = r_acc;
                u_b = r_dc_slow;
                n_mono = $signed(u_sum);
                n_state = S_H3;
            end
            S_H3: begin
                u_a = r_mono;
                u_b = r_hpt;
                u_sub = 1'b1;
                n_acc = $signed(u_sum);
                n_state = S_H4;
            end
            S_H4: begin
                u_a = r_hpt;
                u_b = r_acc >>> HP_SHIFT;
                n_hpt = $signed(u_sum);
                n_state = S_H5;
            end
            S_H5: begin
                u_a = r_mono;
                u_b = r_hpt;
                u_sub = 1'b1;
                n_mono = $signed(u_sum);
                n_state = S_P1;
            end
            S_P1: begin
                // Rectify the filtered value after the shift by 3.
                u_b = r_mono >>> 3;
                u_sub = r_mono[31];
                n_acc = $signed(u_sum);
                n_state = S_P2;
            end
            S_P2: begin
                u_a = r_acc;
                u_b = r_env;
                u_sub = 1'b1;
                if (r_acc >= r_env) begin
                    n_env = r_acc;
                    n_state = S_DCHK;
                end else begin
                    n_acc = $signed(u_sum);
                    n_state = S_P3;
                end
            end
            S_P3: begin
                u_a = r_env;
                u_b = r_acc >>> PEAK_RELEASE_SHIFT;
                n_env = $signed(u_sum);
                n_state = S_DCHK;
            end
            S_DCHK: begin
                if ((r_env > THRESHOLD) && ((r_env >>> 16) > 32'sd0)) begin
                    n_rem = 16'd0;
                    n_quo = PEAK_NUMERATOR;
                    n_cnt = '0;
                    n_state = S_DIV;
                end else begin
                    n_acc = UNITY_GAIN_Q25;
                    n_state = S_G1;
                end
            end
            S_DIV: begin
                // One restoring step: the divisor is the upper half of the envelope.
                u_a = {15'd0, trial};
                u_b = {16'd0, r_env[31:16]};
                u_sub = 1'b1;
                if (u_sum[31]) begin
                    n_rem = trial[15:0];
                end else begin
                    n_rem = u_sum[15:0];
                end
                n_quo = {r_quo[22:0], ~u_sum[31]};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_DQ;
                end
            end
            S_DQ: begin
                n_acc = $signed({r_quo, 8'd0});
                n_state = S_G1;
            end
            S_G1: begin
                u_a = r_acc;
                u_b = r_gain;
                u_sub = 1'b1;
                n_acc = $signed(u_sum);
                n_state = S_G2;
            end
            S_G2: begin
                u_a = r_gain;
                u_b = r_acc[31] ? (r_acc >>> GAIN_ATTACK_SHIFT)
                                : (r_acc >>> GAIN_RELEASE_SHIFT);
                n_gain = $signed(u_sum);
                n_state = S_MUL;
            end
            S_MUL: begin
                n_prod = filt_hi * gain_hi;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || o_sample.ready) begin
                    n_out_valid = 1'b1;
                    if (prod_sh > OUT_HI) begin
                        n_out_sample = OUT_HI[RESULT_W-1:0];
                    end else if (prod_sh < OUT_LO) begin
                        n_out_sample = OUT_LO[RESULT_W-1:0];
                    end else begin
                        n_out_sample = prod_sh[RESULT_W-1:0];
                    end
                    n_out_end = r_end;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
            r_dc_fast <= 32'sd0;
            r_dc_slow <= 32'sd0;
            r_hpt <= 32'sd0;
            r_env <= 32'sd0;
            r_gain <= RESET_GAIN_Q25;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
            r_dc_fast <= n_dc_fast;
            r_dc_slow <= n_dc_slow;
            r_hpt <= n_hpt;
            r_env <= n_env;
            r_gain <= n_gain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mono <= n_mono;
        r_acc <= n_acc;
        r_end <= n_end;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_cnt <= n_cnt;
        r_prod <= n_prod;
        r_out_sample <= n_out_sample;
        r_out_end <= n_out_end;
    end

`ifndef SYNTHESIS
    // An accepted frame always starts the filter sequence.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_F1))
        else $error("accepted frame did not start the filter sequence");

    // The rectified peak envelope can never go negative.
    a_env_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_env[31])
        else $error("peak envelope became negative");

    // The gain chases a non-negative target and so stays non-negative.
    a_gain_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_gain[31])
        else $error("gain became negative");

    // A new sample only appears when the sequencer finishes a frame.
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("output valid rose outside the output step");

    // The division leaves its loop exactly after the last quotient bit.
    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) |=> (r_state == S_DQ))
        else $error("divider did not finish after the last step");
`endif

endmodule

// File: test/dc_blocked_peak_compander_tb.sv
// Self-checking testbench for the DC-blocked peak compander: predicted samples versus o_sample.
module dc_blocked_peak_compander_tb;
    import dbpc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One predicted output request: the saturated sample and the copied block-end flag.
    typedef struct packed {
        logic signed [RESULT_W-1:0] sample;
        logic                       block_end;
    } t_companded;

    // Shapes of the random stimulus. Each segment of random frames uses one of them.
    typedef enum int {
        MODE_WIDEBAND,
        MODE_QUIET,
        MODE_DC_OFFSET,
        MODE_LOUD_SQUARE,
        MODE_SILENCE
    } t_stim_mode;

    localparam int FRAME_TARGET   = 950;
    localparam int PRESSURE_HOLD  = 300;
    localparam int DRAIN_CYCLES   = 100;
    localparam int REPORT_LIMIT   = 10;

    // Holds a private copy of the filter, envelope and gain state, works out the sample
    // that each accepted frame must produce, and compares the samples leaving the block
    // against them in order.
    class compander_scoreboard;
        int fast_dc;
        int slow_dc;
        int hp_state;
        int envelope;
        int gain;
        t_companded expected_samples[$];
        int errors;
        int checked;
        int limited_frames;
        int clipped_frames;

        function new();
            fast_dc  = 0;
            slow_dc  = 0;
            hp_state = 0;
            envelope = 0;
            gain     = RESET_GAIN_Q25;
            errors   = 0;
            checked  = 0;
            limited_frames = 0;
            clipped_frames = 0;
        endfunction

        // Runs one frame through the filter chain, the envelope and the gain smoother.
        // All int arithmetic wraps at 32 bits and >>> is a floor shift, as in the block.
        function void note_frame(logic signed [SAMPLE_W-1:0] left, logic signed [SAMPLE_W-1:0] right,
                                 logic block_end);
            int mono;
            int fast_sat;
            int hp_in;
            int filtered;
            int rect;
            int env_hi;
            int target;
            int delta;
            longint prod;
            t_companded entry;

            mono = (int'(left) + int'(right)) <<< 4;

            fast_dc += (mono - fast_dc) >>> DC_FAST_SHIFT;
            if (fast_dc > SAT24_HI)
                fast_sat = SAT24_HI;
            else if (fast_dc < SAT24_LO)
                fast_sat = SAT24_LO;
            else
                fast_sat = fast_dc;
            slow_dc += (fast_sat - slow_dc) >>> DC_SLOW_SHIFT;

            hp_in = mono - fast_dc + slow_dc;
            hp_state += (hp_in - hp_state) >>> HP_SHIFT;
            filtered = hp_in - hp_state;

            // Instant attack, slow release on the rectified, scaled-down value.
            rect = filtered >>> 3;
            if (rect < 0)
                rect = -rect;
            if (rect >= envelope)
                envelope = rect;
            else
                envelope += (rect - envelope) >>> PEAK_RELEASE_SHIFT;

            target = UNITY_GAIN_Q25;
            env_hi = envelope >>> 16;
            if (envelope > THRESHOLD && env_hi > 0) begin
                target = (int'(PEAK_NUMERATOR) / env_hi) * 256;
                limited_frames++;
            end

            // Gain falls quickly toward a lower target and recovers slowly.
            delta = target - gain;
            if (delta < 0)
                gain += delta >>> GAIN_ATTACK_SHIFT;
            else
                gain += delta >>> GAIN_RELEASE_SHIFT;

            prod = (longint'(filtered >>> 11) * longint'(gain >>> 10)) >>> 8;
            if (prod > OUT_HI) begin
                prod = OUT_HI;
                clipped_frames++;
            end else if (prod < OUT_LO) begin
                prod = OUT_LO;
                clipped_frames++;
            end

            entry.sample    = prod[RESULT_W-1:0];
            entry.block_end = block_end;
            expected_samples.push_back(entry);
        endfunction

        function void check_sample(logic signed [RESULT_W-1:0] sample, logic block_end);
            t_companded want;

            checked++;
            if (expected_samples.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: sample %0d (block_end %0b) arrived with no frame pending",
                             $realtime, sample, block_end);
                return;
            end
            want = expected_samples.pop_front();
            if (sample !== want.sample || block_end !== want.block_end) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: sample #%0d expected %0d/%0b, got %0d/%0b", $realtime,
                             checked, want.sample, want.block_end, sample, block_end);
            end
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    dbpc_frame_if  frame_if();
    dbpc_sample_if sample_if();

    dc_blocked_peak_compander dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (frame_if),
        .o_sample (sample_if)
    );

    compander_scoreboard compander_sb;

    // Idling switches, changed per segment by the stimulus; pressure_request asks the
    // receiving side for one long hold-off, which it times itself.
    bit sender_idles;
    bit receiver_idles;
    bit pressure_request;
    int pressure_holds;
    int frames_sent;
    int input_stall_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Gap lengths: mostly none or a few cycles, now and then a long one.
    function automatic int pick_gap(bit enabled);
        int roll;

        if (!enabled)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offers one frame and returns once it has been accepted. Valid is only dropped when
    // a gap precedes the frame, so back-to-back frames keep it high without a glitch.
    task automatic send_frame(input logic signed [SAMPLE_W-1:0] left,
                              input logic signed [SAMPLE_W-1:0] right, input logic block_end);
        int gap;

        gap = pick_gap(sender_idles);
        if (gap > 0) begin
            frame_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        frame_if.valid        <= 1'b1;
        frame_if.left_sample  <= left;
        frame_if.right_sample <= right;
        frame_if.block_end    <= block_end;
        do
            @(posedge i_clk);
        while (!frame_if.ready);
        compander_sb.note_frame(left, right, block_end);
        frames_sent++;
    endtask

    // One run of random frames in a single shape. Loud square waves push the envelope over
    // the limiting threshold, silence lets it and the gain recover, the DC segments load the
    // trackers, and wideband noise toggles every bit of both channels.
    task automatic run_segment(input int length);
        t_stim_mode mode;
        int period;
        logic signed [SAMPLE_W-1:0] dc_level;
        logic signed [SAMPLE_W-1:0] amplitude;
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;

        mode      = t_stim_mode'($urandom_range(0, 4));
        dc_level  = SAMPLE_W'($urandom);
        amplitude = SAMPLE_W'($urandom_range(1 << 20, 8388607));
        period    = $urandom_range(1, 16);
        for (int n = 0; n < length; n++) begin
            case (mode)
                MODE_WIDEBAND: begin
                    left  = SAMPLE_W'($urandom);
                    right = SAMPLE_W'($urandom);
                end
                MODE_QUIET: begin
                    left  = SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
                    right = SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
                end
                MODE_DC_OFFSET: begin
                    left  = dc_level + SAMPLE_W'($urandom_range(0, 127)) - SAMPLE_W'(64);
                    right = dc_level + SAMPLE_W'($urandom_range(0, 127)) - SAMPLE_W'(64);
                end
                MODE_LOUD_SQUARE: begin
                    left  = ((n / period) % 2) ? amplitude : -amplitude;
                    right = {left[SAMPLE_W-1:8], 8'($urandom)};
                end
                default: begin
                    left  = '0;
                    right = '0;
                end
            endcase
            send_frame(left, right, $urandom_range(0, 7) == 0);
        end
    endtask

    // Output side: checks every accepted sample and decides ready for the next cycle.
    // The long hold-off is counted here, independent of what the sender is doing, so the
    // output register fills and the block has to refuse further frames.
    initial begin
        int hold_left;
        int stall;

        hold_left = 0;
        sample_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && sample_if.valid && sample_if.ready)
                compander_sb.check_sample(sample_if.companded_sample, sample_if.block_end_out);
            if (frame_if.valid && !frame_if.ready)
                input_stall_cycles++;
            if (hold_left > 0) begin
                hold_left--;
                sample_if.ready <= 1'b0;
            end else if (pressure_request) begin
                pressure_request = 1'b0;
                pressure_holds++;
                hold_left = PRESSURE_HOLD - 1;
                sample_if.ready <= 1'b0;
            end else begin
                stall = pick_gap(receiver_idles);
                if (stall > 0) begin
                    hold_left = stall - 1;
                    sample_if.ready <= 1'b0;
                end else begin
                    sample_if.ready <= 1'b1;
                end
            end
        end
    end

    // Hard limit on the whole run, far beyond the slowest legal schedule.
    initial begin
        #10ms;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int drain;

        compander_sb   = new();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        pressure_request = 1'b0;
        pressure_holds = 0;
        frames_sent    = 0;
        input_stall_cycles = 0;

        i_rst_n               <= 1'b0;
        frame_if.valid        <= 1'b0;
        frame_if.left_sample  <= '0;
        frame_if.right_sample <= '0;
        frame_if.block_end    <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames: silence, full-scale steps of both polarities that drive the
        // envelope over the threshold and clip the output, opposite channels that cancel,
        // single-LSB values, and block_end set and clear.
        send_frame('0, '0, 1'b0);
        send_frame(24'sd8388607, 24'sd8388607, 1'b1);
        send_frame(24'sd8388607, 24'sd8388607, 1'b0);
        send_frame(24'sd8388607, 24'sd8388607, 1'b0);
        send_frame(-24'sd8388608, -24'sd8388608, 1'b1);
        send_frame(-24'sd8388608, -24'sd8388608, 1'b0);
        send_frame(-24'sd8388608, 24'sd8388607, 1'b0);
        send_frame(24'sd8388607, -24'sd8388608, 1'b1);
        for (int n = 0; n < 6; n++)
            send_frame((n % 2) ? -24'sd8388608 : 24'sd8388607,
                       (n % 2) ? -24'sd8388608 : 24'sd8388607, n == 5);
        send_frame(24'sd1, -24'sd1, 1'b0);
        send_frame(-24'sd1, -24'sd1, 1'b1);
        send_frame(24'sd1, 24'sd1, 1'b0);
        send_frame('0, '0, 1'b1);
        send_frame(24'sd4194304, -24'sd4194304, 1'b0);
        send_frame(24'sd2097152, 24'sd2097152, 1'b0);

        // Random segments, each with its own idling on either side; some run flat out.
        while (frames_sent < FRAME_TARGET) begin
            sender_idles   = $urandom_range(0, 3) != 0;
            receiver_idles = $urandom_range(0, 3) != 0;
            if (pressure_holds == 0 && frames_sent >= 300) begin
                sender_idles     = 1'b0;
                pressure_request = 1'b1;
            end
            run_segment($urandom_range(8, 60));
        end
        frame_if.valid <= 1'b0;

        while (compander_sb.pending() != 0)
            @(posedge i_clk);
        // Stray samples after the last expected one would still be caught here.
        for (drain = 0; drain < DRAIN_CYCLES; drain++)
            @(posedge i_clk);

        $display("Sent %0d frames, checked %0d samples; %0d frames above the limit threshold,",
                 frames_sent, compander_sb.checked, compander_sb.limited_frames);
        $display("%0d clipped outputs, %0d long output hold-offs, %0d input stall cycles.",
                 compander_sb.clipped_frames, pressure_holds, input_stall_cycles);
        if (compander_sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatching samples", compander_sb.errors);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
